// ===== hdl/cuodf_pkg.sv =====
// Shared constants and types for the CAN-over-UDP record deframer.
`default_nettype none

package cuodf_pkg;

  // Header length default; the top level takes it as a parameter.
  localparam int HEADER_BYTES_DEF = 16;

  // Record layout: 4 id bytes, flags, length code, 8 data bytes.
  localparam int REC_BYTES  = 14;
  localparam int REC_POS_W  = $clog2(REC_BYTES);
  localparam logic [REC_POS_W-1:0] REC_LAST = REC_POS_W'(REC_BYTES - 1);

  localparam int DATA_BYTES = 8;

  localparam logic [31:0] EXT_ID_BAD_MASK = 32'hE000_0000;
  localparam logic [31:0] STD_ID_MAX      = 32'h0000_07FF;
  localparam logic [7:0]  MAX_DATA_LEN    = 8'd8;

  // Status codes.
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_BAD_EXT = 2'd1;
  localparam logic [1:0] STATUS_BAD_STD = 2'd2;
  localparam logic [1:0] STATUS_BAD_LEN = 2'd3;

  // Output beat: id, length code, data, status, zero-filled to whole bytes.
  localparam int OUT_FIELDS_W = 32 + 8 + 64 + 2;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // One complete record, byte 0 in element 0.
  typedef logic [REC_BYTES-1:0][7:0] rec_t;

endpackage

`default_nettype wire

// ===== hdl/can_over_udp_record_deframer_unit.sv =====
// CAN-over-UDP record deframer: payload byte stream in, decoded CAN records out.
//
// s_axis carries datagram payload, one byte per beat in tdata, with tlast on
// the final byte. The first HEADER_BYTES bytes of each datagram are skipped;
// the rest is cut into 14-byte records. Each complete record yields one
// m_axis beat with id, length code, masked data bytes and a status code;
// tuser carries the extended-id flag. Datagrams shorter than the header and
// trailing partial records produce nothing.
// Latency: a record's last byte accepted on s_axis passes through two register
// stages (record register, then result register) before it appears on m_axis.
// Throughput: one byte per cycle while m_axis does not stall; a record needs
// 14 byte beats, so each result beat takes 14 accepted record bytes.
// Reset clears the header and record counters and both valid flags; the
// block restarts at the header of a new datagram.
// When m_axis stalls, the result register holds its beat, the record
// register fills behind it, and s_axis_tready drops only once both are full.
`default_nettype none

module can_over_udp_record_deframer_unit
  import cuodf_pkg::*;
#(
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [7:0]             s_axis_tdata,   // payload_byte
  input  wire logic                   s_axis_tlast,   // end_of_datagram
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // frame_id[31:0], length_code[39:32], frame_data[103:40], status[105:104]
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                        m_axis_tuser    // is_extended
);

  logic        rec_valid;
  logic        rec_ready;
  rec_t        rec;
  logic [31:0] out_id;
  logic [7:0]  out_len;
  logic [63:0] out_data;
  logic [1:0]  out_status;

  cuodf_collect #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_collect (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_byte   (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec       (rec)
  );

  cuodf_format u_format (
    .clk        (clk),
    .rst        (rst),
    .rec_valid  (rec_valid),
    .rec_ready  (rec_ready),
    .rec        (rec),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_id     (out_id),
    .out_ext    (m_axis_tuser),
    .out_len    (out_len),
    .out_data   (out_data),
    .out_status (out_status)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), out_status, out_data, out_len, out_id};

endmodule

`default_nettype wire

// ===== hdl/cuodf_collect.sv =====
// Header skip, record position tracking and record byte store.
`default_nettype none

module cuodf_collect
  import cuodf_pkg::*;
#(
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            rec_valid,
  input  wire logic       rec_ready,
  output rec_t            rec
);

  localparam int HDR_W = $clog2(HEADER_BYTES + 1);

  logic [HDR_W-1:0]     header_left;
  logic [REC_POS_W-1:0] record_position;
  logic [7:0]           record_bytes [REC_BYTES-1];
  logic                 accept;
  logic                 in_body;
  logic                 rec_done;

  assign in_ready = !rec_valid || rec_ready;
  assign accept   = in_valid && in_ready;
  assign in_body  = (header_left == '0);
  assign rec_done = accept && in_body && (record_position == REC_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      header_left     <= HDR_W'(HEADER_BYTES);
      record_position <= '0;
      rec_valid       <= 1'b0;
    end else begin
      if (rec_valid && rec_ready) begin
        rec_valid <= 1'b0;
      end
      if (rec_done) begin
        rec_valid <= 1'b1;
      end
      if (accept) begin
        if (!in_body) begin
          header_left <= header_left - 1'b1;
        end else if (record_position == REC_LAST) begin
          record_position <= '0;
        end else begin
          record_position <= record_position + 1'b1;
        end
        // restart header skip on the last beat of a datagram
        if (in_last) begin
          header_left     <= HDR_W'(HEADER_BYTES);
          record_position <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_body && (record_position != REC_LAST)) begin
      record_bytes[record_position] <= in_byte;
    end
    if (rec_done) begin
      for (int i = 0; i < REC_BYTES - 1; i++) begin
        rec[i] <= record_bytes[i];
      end
      rec[REC_BYTES-1] <= in_byte;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cuodf_format.sv =====
// Record decode, data masking, status check and output register.
`default_nettype none

module cuodf_format
  import cuodf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        rec_valid,
  output logic             rec_ready,
  input  wire rec_t        rec,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_id,
  output logic             out_ext,
  output logic [7:0]       out_len,
  output logic [63:0]      out_data,
  output logic [1:0]       out_status
);

  logic [31:0] id;
  logic        ext;
  logic [7:0]  len;
  logic [63:0] data;
  logic [1:0]  status;
  logic        load;

  assign rec_ready = !out_valid || out_ready;
  assign load      = rec_valid && rec_ready;

  always_comb begin
    id  = {rec[0], rec[1], rec[2], rec[3]};
    ext = rec[4][0];
    len = rec[5];
    // zero bytes at or past the length code
    for (int i = 0; i < DATA_BYTES; i++) begin
      data[8*i +: 8] = (8'(i) < len) ? rec[6+i] : 8'h00;
    end
    priority if (ext && ((id & EXT_ID_BAD_MASK) != '0)) begin
      status = STATUS_BAD_EXT;
    end else if (!ext && ((id & ~STD_ID_MAX) != '0)) begin
      status = STATUS_BAD_STD;
    end else if (len > MAX_DATA_LEN) begin
      status = STATUS_BAD_LEN;
    end else begin
      status = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_id     <= id;
      out_ext    <= ext;
      out_len    <= len;
      out_data   <= data;
      out_status <= status;
    end
  end

endmodule

`default_nettype wire
